### rtl/isq_pkg.sv
`default_nettype none
package isq_pkg;

  localparam int unsigned DataW = 64;

  // register indexes of the configuration port
  typedef enum logic {
    REG_STEP_SIZE = 1'b0,
    REG_ELEM_TYPE = 1'b1
  } cfg_reg_e;

  // item moving through the divider cells
  typedef struct packed {
    logic             last;
    logic             neg;
    logic [DataW-1:0] mag;
    logic [DataW-1:0] rem;
  } div_item_t;

  // item after the remainder compare
  typedef struct packed {
    logic             last;
    logic             neg;
    logic             up;
    logic [DataW-1:0] base;
  } rnd_item_t;

  // all-ones mask over the low type width
  function automatic logic [DataW-1:0] type_mask(input logic [2:0] sel);
    logic [DataW-1:0] m;
    unique case (sel[1:0])
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  // sign bit position as a one-hot word
  function automatic logic [DataW-1:0] type_sign(input logic [2:0] sel);
    logic [DataW-1:0] m;
    m = type_mask(sel);
    return m ^ (m >> 1);
  endfunction

endpackage
`default_nettype wire

### rtl/integer_step_quantizer.sv
// integer_step_quantizer: snaps integer samples to the nearest multiple of
// a programmed step, ties away from zero on the magnitude, with saturation.
// Input channel: valid_i / stall_o with sample_i and last_in_i.
// Output channel: valid_o / stall_i with quantized_o and last_out_o.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 step_size, 1 elem_type); write only while the block is empty.
// The pipeline has one prepare stage, 64 division cells (one quotient bit
// each, a row of restoring subtract cells), a compare stage and the output
// register. Throughput is one transaction per cycle while not stalled.
// Reset empties the pipeline and loads step 1, element type 0.
// While the receiver stalls a valid result, the whole row holds and
// stall_o is raised; otherwise a new sample enters every cycle.
`default_nettype none
module integer_step_quantizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [63:0] sample_i,
  input  wire logic        last_in_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [63:0]      quantized_o,
  output logic             last_out_o
);

  localparam int unsigned NCells = isq_pkg::DataW;

  logic [63:0] step_q, step_eff;
  logic [2:0]  type_q;
  logic        en;
  logic               cvalid [NCells+1];
  isq_pkg::div_item_t citem  [NCells+1];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 64'd1;
      type_q <= 3'd0;
    end else if (cfg_we_i) begin
      unique case (isq_pkg::cfg_reg_e'(cfg_idx_i))
        isq_pkg::REG_STEP_SIZE: step_q <= cfg_wdata_i;
        isq_pkg::REG_ELEM_TYPE: type_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign step_eff = (step_q == '0) ? 64'd1 : step_q;

  // advance the row unless a result is held
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  isq_prep u_prep (
    .clk_i, .rst_ni, .en_i(en), .valid_i, .sample_i, .last_i(last_in_i),
    .elem_type_i(type_q), .valid_o(cvalid[0]), .item_o(citem[0])
  );

  for (genvar k = 0; k < NCells; k++) begin : g_cell
    isq_div_cell #(.BitIdx(NCells - 1 - k)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .step_i(step_eff),
      .valid_i(cvalid[k]), .item_i(citem[k]),
      .valid_o(cvalid[k+1]), .item_o(citem[k+1])
    );
  end

  isq_round u_round (
    .clk_i, .rst_ni, .en_i(en), .step_i(step_eff), .elem_type_i(type_q),
    .valid_i(cvalid[NCells]), .item_i(citem[NCells]),
    .valid_o, .quantized_o, .last_o(last_out_o)
  );

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i) else $error("stall without held result");
  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (quantized_o & ~isq_pkg::type_mask(type_q)) == '0)
    else $error("bits above type width set");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(quantized_o))
    else $error("held result changed");

endmodule
`default_nettype wire

### rtl/isq_prep.sv
`default_nettype none
module isq_prep (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [isq_pkg::DataW-1:0]      sample_i,
  input  wire logic                           last_i,
  input  wire logic [2:0]                     elem_type_i,
  output logic                                valid_o,
  output isq_pkg::div_item_t                  item_o
);

  logic                      valid_q;
  isq_pkg::div_item_t        item_q, item_d;
  logic [isq_pkg::DataW-1:0] mask, raw;

  // take magnitude and sign of the masked sample
  always_comb begin
    mask        = isq_pkg::type_mask(elem_type_i);
    raw         = sample_i & mask;
    item_d.last = last_i;
    item_d.neg  = elem_type_i[2] && ((raw & isq_pkg::type_sign(elem_type_i)) != '0);
    item_d.mag  = item_d.neg ? ((~raw + 64'd1) & mask) : raw;
    item_d.rem  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

### rtl/isq_div_cell.sv
`default_nettype none
module isq_div_cell #(
  parameter int unsigned BitIdx = 63
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic [isq_pkg::DataW-1:0] step_i,
  input  wire logic                      valid_i,
  input  wire isq_pkg::div_item_t        item_i,
  output logic                           valid_o,
  output isq_pkg::div_item_t             item_o
);

  logic               valid_q;
  isq_pkg::div_item_t item_q, item_d;
  logic [isq_pkg::DataW:0] trial;

  // one restoring division step on the remainder
  always_comb begin
    item_d = item_i;
    trial  = {item_i.rem, item_i.mag[BitIdx]};
    if (trial >= {1'b0, step_i}) begin
      trial = trial - {1'b0, step_i};
    end
    item_d.rem = trial[isq_pkg::DataW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

### rtl/isq_round.sv
`default_nettype none
module isq_round (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic [isq_pkg::DataW-1:0] step_i,
  input  wire logic [2:0]                elem_type_i,
  input  wire logic                      valid_i,
  input  wire isq_pkg::div_item_t        item_i,
  output logic                           valid_o,
  output logic [isq_pkg::DataW-1:0]      quantized_o,
  output logic                           last_o
);

  logic                      rvalid_q, ovalid_q;
  isq_pkg::rnd_item_t        rnd_q, rnd_d;
  logic [isq_pkg::DataW-1:0] q_q, q_d, mask, sgn, lim;
  logic                      last_q;
  logic [isq_pkg::DataW:0]   r;

  // decide rounding direction and the lower multiple
  always_comb begin
    rnd_d.last = item_i.last;
    rnd_d.neg  = item_i.neg;
    rnd_d.up   = item_i.rem >= (step_i - (step_i >> 1));
    rnd_d.base = item_i.mag - item_i.rem;
  end

  // add the step, clamp to the type range, restore the sign
  always_comb begin
    mask = isq_pkg::type_mask(elem_type_i);
    sgn  = isq_pkg::type_sign(elem_type_i);
    r    = {1'b0, rnd_q.base} + (rnd_q.up ? {1'b0, step_i} : '0);
    if (!elem_type_i[2]) begin
      lim = mask;
    end else if (rnd_q.neg) begin
      lim = sgn;
    end else begin
      lim = sgn - 64'd1;
    end
    if (r > {1'b0, lim}) begin
      r = {1'b0, lim};
    end
    q_d = rnd_q.neg ? ((~r[isq_pkg::DataW-1:0] + 64'd1) & mask)
                    : (r[isq_pkg::DataW-1:0] & mask);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else if (en_i) begin
      rvalid_q <= valid_i;
      ovalid_q <= rvalid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rnd_q  <= rnd_d;
      q_q    <= q_d;
      last_q <= rnd_q.last;
    end
  end

  assign valid_o     = ovalid_q;
  assign quantized_o = q_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire
